>>> rtl/dxtd_pkg.sv
// shared types, format codes and arithmetic helpers for the block decoder
package dxtd_pkg;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  localparam logic [15:0] ROW_STRIDE_RST = 16'd16;

  // reciprocals scaled by 2^16, exact over the sum ranges used here
  localparam logic [14:0] DIV3_MUL = 15'd21846;
  localparam logic [13:0] DIV5_MUL = 14'd13108;
  localparam logic [13:0] DIV7_MUL = 14'd9363;

  typedef struct packed {
    logic [63:0] colour_half;
    logic [63:0] alpha_half;
    logic [1:0]  block_format;
    logic [2:0]  cols_valid;
    logic [2:0]  rows_valid;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha_out;
    logic [1:0]  pixel_x;
    logic [1:0]  pixel_y;
    logic [17:0] byte_offset;
    logic        last_pixel;
  } out_item_t;

  // expanded endpoints and weighted sums ahead of the divides
  typedef struct packed {
    logic [1:0][2:0][7:0] ends;
    logic [2:0][9:0]      mix2;
    logic [2:0][9:0]      mix3;
    logic                 four_col;
    logic [7:0]           a0;
    logic [7:0]           a1;
    logic [5:0][10:0]     amix;
    logic                 alpha7;
    logic [63:0]          alpha_half;
    logic [31:0]          idx;
    logic [1:0]           fmt;
    logic [2:0]           cols;
    logic [2:0]           rows;
  } prep_t;

  // fully decoded block, read out one pixel at a time
  typedef struct packed {
    logic [3:0][2:0][7:0] pal;
    logic                 trans3;
    logic [7:0][7:0]      atab;
    logic [63:0]          alpha_half;
    logic [31:0]          idx;
    logic [1:0]           fmt;
    logic [2:0]           cols;
    logic [2:0]           rows;
  } blk_t;

  // v*255/31 truncated: 8v plus floor(7v/31)
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [2:0] c;
    c = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
      + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
    return {v, 3'b000} + {5'b0, c};
  endfunction

  // v*255/63 truncated: 4v plus floor(v/21)
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [1:0] c;
    c = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
    return {v, 2'b00} + {6'b0, c};
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'(DIV3_MUL);
    return p[23:16];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'(DIV5_MUL);
    return p[23:16];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'(DIV7_MUL);
    return p[23:16];
  endfunction

endpackage

>>> rtl/dxtd_prep.sv
// input stage: endpoint expansion and weighted palette and alpha sums
module dxtd_prep import dxtd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     next_ready,
  output logic     prep_valid,
  output prep_t    prep
);

  logic       valid_r;
  prep_t      prep_r;
  prep_t      prep_nxt;
  logic       take;
  logic [15:0] c0;
  logic [15:0] c1;
  logic [7:0]  e0;
  logic [7:0]  e1;
  logic [7:0]  a0;
  logic [7:0]  a1;

  assign in_stall   = valid_r && !next_ready;
  assign take       = in_valid && !in_stall;
  assign prep_valid = valid_r;
  assign prep       = prep_r;

  always_comb begin
    c0 = in_data.colour_half[15:0];
    c1 = in_data.colour_half[31:16];
    a0 = in_data.alpha_half[7:0];
    a1 = in_data.alpha_half[15:8];
    e0 = '0;
    e1 = '0;
    prep_nxt = '0;
    prep_nxt.ends[0][0] = expand5(c0[15:11]);
    prep_nxt.ends[0][1] = expand6(c0[10:5]);
    prep_nxt.ends[0][2] = expand5(c0[4:0]);
    prep_nxt.ends[1][0] = expand5(c1[15:11]);
    prep_nxt.ends[1][1] = expand6(c1[10:5]);
    prep_nxt.ends[1][2] = expand5(c1[4:0]);
    prep_nxt.four_col = (in_data.block_format != FMT_DXT1) || (c0 > c1);
    for (int ch = 0; ch < 3; ch++) begin
      e0 = prep_nxt.ends[0][ch];
      e1 = prep_nxt.ends[1][ch];
      // three-colour mode only needs the plain sum for the midpoint
      prep_nxt.mix2[ch] = prep_nxt.four_col ? (10'({e0, 1'b0}) + 10'(e1))
                                            : (10'(e0) + 10'(e1));
      prep_nxt.mix3[ch] = 10'(e0) + 10'({e1, 1'b0});
    end
    prep_nxt.a0 = a0;
    prep_nxt.a1 = a1;
    prep_nxt.alpha7 = a0 > a1;
    for (int k = 1; k < 7; k++) begin
      if (prep_nxt.alpha7) begin
        prep_nxt.amix[k-1] = 11'((7 - k) * a0) + 11'(k * a1);
      end else if (k <= 4) begin
        prep_nxt.amix[k-1] = 11'((5 - k) * a0) + 11'(k * a1);
      end else begin
        prep_nxt.amix[k-1] = '0;
      end
    end
    prep_nxt.alpha_half = in_data.alpha_half;
    prep_nxt.idx  = in_data.colour_half[63:32];
    prep_nxt.fmt  = in_data.block_format;
    prep_nxt.cols = (in_data.cols_valid > 3'd4) ? 3'd4 : in_data.cols_valid;
    prep_nxt.rows = (in_data.rows_valid > 3'd4) ? 3'd4 : in_data.rows_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || next_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

>>> rtl/dxtd_table.sv
// divide stage: builds the colour palette and alpha table into the block register
module dxtd_table import dxtd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  prep_valid,
  input  prep_t prep,
  output logic  next_ready,
  input  logic  blk_done,
  output logic  blk_valid,
  output blk_t  blk
);

  logic blk_valid_r;
  blk_t blk_r;
  blk_t blk_nxt;

  assign next_ready = !blk_valid_r || blk_done;
  assign blk_valid  = blk_valid_r;
  assign blk        = blk_r;

  always_comb begin
    blk_nxt = '0;
    blk_nxt.pal[0] = prep.ends[0];
    blk_nxt.pal[1] = prep.ends[1];
    for (int ch = 0; ch < 3; ch++) begin
      blk_nxt.pal[2][ch] = prep.four_col ? div3(prep.mix2[ch]) : prep.mix2[ch][8:1];
      blk_nxt.pal[3][ch] = prep.four_col ? div3(prep.mix3[ch]) : 8'd0;
    end
    blk_nxt.trans3 = !prep.four_col;
    blk_nxt.atab[0] = prep.a0;
    blk_nxt.atab[1] = prep.a1;
    for (int k = 1; k < 7; k++) begin
      if (prep.alpha7) begin
        blk_nxt.atab[k+1] = div7(prep.amix[k-1]);
      end else if (k <= 4) begin
        blk_nxt.atab[k+1] = div5(prep.amix[k-1]);
      end else if (k == 5) begin
        blk_nxt.atab[k+1] = 8'd0;
      end else begin
        blk_nxt.atab[k+1] = 8'd255;
      end
    end
    blk_nxt.alpha_half = prep.alpha_half;
    blk_nxt.idx  = prep.idx;
    blk_nxt.fmt  = prep.fmt;
    blk_nxt.cols = prep.cols;
    blk_nxt.rows = prep.rows;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
    end else if (next_ready) begin
      blk_valid_r <= prep_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (next_ready && prep_valid) begin
      blk_r <= blk_nxt;
    end
  end

endmodule

>>> rtl/dxtd_emit.sv
// pixel walker: steps through the clip rectangle and fills the result register
module dxtd_emit import dxtd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        blk_valid,
  input  blk_t        blk,
  input  logic [15:0] row_stride,
  output logic        blk_done,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic [1:0] x_r;
  logic [1:0] y_r;
  logic       out_valid_r;
  out_item_t  out_r;
  out_item_t  out_nxt;
  logic       out_free;
  logic       empty;
  logic       last_x;
  logic       last;
  logic       emit;
  logic [3:0] p;
  logic [1:0] ci;
  logic [3:0] nib;
  logic [5:0] apos;
  logic [2:0] aidx;

  assign empty    = (blk.cols == 3'd0) || (blk.rows == 3'd0);
  assign last_x   = ({1'b0, x_r} + 3'd1) == blk.cols;
  assign last     = last_x && (({1'b0, y_r} + 3'd1) == blk.rows);
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = blk_valid && out_free && !empty;
  // an empty clip retires the block without a transaction
  assign blk_done = blk_valid && (empty || (emit && last));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    p    = {y_r, x_r};
    ci   = blk.idx[{p, 1'b0} +: 2];
    nib  = blk.alpha_half[{p, 2'b00} +: 4];
    apos = 6'd16 + 6'({p, 1'b0}) + 6'(p);
    aidx = blk.alpha_half[apos +: 3];
    out_nxt = '0;
    out_nxt.red   = blk.pal[ci][0];
    out_nxt.green = blk.pal[ci][1];
    out_nxt.blue  = blk.pal[ci][2];
    unique case (blk.fmt)
      FMT_DXT1: out_nxt.alpha_out = (blk.trans3 && (ci == 2'd3)) ? 8'd0 : 8'd255;
      FMT_DXT3: out_nxt.alpha_out = {nib, nib};
      FMT_DXT5: out_nxt.alpha_out = blk.atab[aidx];
      default:  out_nxt.alpha_out = 8'd255;
    endcase
    out_nxt.pixel_x     = x_r;
    out_nxt.pixel_y     = y_r;
    out_nxt.byte_offset = ({2'b00, row_stride} * {16'b0, y_r}) + {14'b0, x_r, 2'b00};
    out_nxt.last_pixel  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= 2'd0;
      y_r <= 2'd0;
    end else if (blk_done) begin
      x_r <= 2'd0;
      y_r <= 2'd0;
    end else if (emit) begin
      if (last_x) begin
        x_r <= 2'd0;
        y_r <= y_r + 2'd1;
      end else begin
        x_r <= x_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> rtl/dxt_block_decode.sv
// path: an accepted block passes the prep register and the block register before the result register
// throughput: one pixel per cycle while out_stall is low, cols*rows pixels per block (none for
// an empty clip), set by the pixel walker that feeds the single result register
// blocks overlap: the next block is decoded while the current one is still being walked
// reset: synchronous active low, empties the pipeline and sets the row stride to 16
module dxt_block_decode import dxtd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] row_stride_r;
  logic        prep_valid;
  prep_t       prep;
  logic        next_ready;
  logic        blk_valid;
  blk_t        blk;
  logic        blk_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_stride_r <= ROW_STRIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      row_stride_r <= cfg_data;
    end
  end

  dxtd_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .next_ready (next_ready),
    .prep_valid (prep_valid),
    .prep       (prep)
  );

  dxtd_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .prep_valid (prep_valid),
    .prep       (prep),
    .next_ready (next_ready),
    .blk_done   (blk_done),
    .blk_valid  (blk_valid),
    .blk        (blk)
  );

  dxtd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .blk_valid  (blk_valid),
    .blk        (blk),
    .row_stride (row_stride_r),
    .blk_done   (blk_done),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> rtl/dxtd_checker.sv
// port-level checks for the block decoder and their bind to the top level
module dxtd_checker import dxtd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_data
);

  // a stalled result transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the first row sits at offset x*4 whatever the stride
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pixel_y == 2'd0)
      |-> out_data.byte_offset == {14'b0, out_data.pixel_x, 2'b00})
    else $error("bad byte offset on first row");

  // the bottom right pixel always closes a block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pixel_x == 2'd3) && (out_data.pixel_y == 2'd3)
      |-> out_data.last_pixel)
    else $error("corner pixel not marked last");

endmodule

bind dxt_block_decode dxtd_checker u_dxtd_checker (.*);

>>> tb/sv/dxt_pixel_checker.sv
// pixel predictor and result comparator for the block decoder testbench
module dxt_pixel_checker import dxtd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [15:0] cfg_data,
  output int        fail_count,
  output int        pending
);

  out_item_t   pixel_q[$];
  out_item_t   want_px;
  logic [15:0] row_stride;
  bit          px_bad;

  function automatic bit field_bad(input string name, input int unsigned want,
                                   input int unsigned got);
    if (want == got) return 1'b0;
    $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    return 1'b1;
  endfunction

  // expands one compressed block into the pixels it should produce
  task automatic decode_pixels(input in_item_t blk);
    logic [15:0] c0;
    logic [15:0] c1;
    logic [31:0] idx;
    int unsigned pal[4][4];
    int unsigned alpha[16];
    int unsigned tab[8];
    int unsigned a0;
    int unsigned a1;
    int unsigned w;
    int unsigned h;
    int unsigned p;
    int unsigned sel;
    out_item_t   px;

    c0  = blk.colour_half[15:0];
    c1  = blk.colour_half[31:16];
    idx = blk.colour_half[63:32];
    w = (blk.cols_valid > 3'd4) ? 4 : blk.cols_valid;
    h = (blk.rows_valid > 3'd4) ? 4 : blk.rows_valid;

    pal[0][0] = c0[15:11] * 255 / 31;
    pal[0][1] = c0[10:5] * 255 / 63;
    pal[0][2] = c0[4:0] * 255 / 31;
    pal[1][0] = c1[15:11] * 255 / 31;
    pal[1][1] = c1[10:5] * 255 / 63;
    pal[1][2] = c1[4:0] * 255 / 31;
    for (int e = 0; e < 4; e++) pal[e][3] = 255;

    if (blk.block_format != FMT_DXT1 || c0 > c1) begin
      for (int k = 0; k < 3; k++) begin
        pal[2][k] = (2 * pal[0][k] + pal[1][k]) / 3;
        pal[3][k] = (pal[0][k] + 2 * pal[1][k]) / 3;
      end
    end else begin
      // three colours plus transparent black
      for (int k = 0; k < 3; k++) begin
        pal[2][k] = (pal[0][k] + pal[1][k]) / 2;
        pal[3][k] = 0;
      end
      pal[3][3] = 0;
    end

    for (int i = 0; i < 16; i++) alpha[i] = 255;
    if (blk.block_format == FMT_DXT3) begin
      for (int i = 0; i < 16; i++) alpha[i] = blk.alpha_half[4*i +: 4] * 17;
    end else if (blk.block_format == FMT_DXT5) begin
      a0 = blk.alpha_half[7:0];
      a1 = blk.alpha_half[15:8];
      tab[0] = a0;
      tab[1] = a1;
      if (a0 > a1) begin
        for (int k = 1; k < 7; k++) tab[k+1] = ((7 - k) * a0 + k * a1) / 7;
      end else begin
        for (int k = 1; k < 5; k++) tab[k+1] = ((5 - k) * a0 + k * a1) / 5;
        tab[6] = 0;
        tab[7] = 255;
      end
      for (int i = 0; i < 16; i++) alpha[i] = tab[blk.alpha_half[16+3*i +: 3]];
    end

    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        p   = y * 4 + x;
        sel = idx[2*p +: 2];
        px.red         = 8'(pal[sel][0]);
        px.green       = 8'(pal[sel][1]);
        px.blue        = 8'(pal[sel][2]);
        px.alpha_out   = 8'((blk.block_format == FMT_DXT1) ? pal[sel][3] : alpha[p]);
        px.pixel_x     = 2'(x);
        px.pixel_y     = 2'(y);
        px.byte_offset = 18'(y * row_stride + x * 4);
        px.last_pixel  = (y == h - 1) && (x == w - 1);
        pixel_q.push_back(px);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      row_stride = ROW_STRIDE_RST;
      pixel_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) row_stride = cfg_data;
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel transaction, expected none got %h", $time, out_data);
          fail_count++;
        end else begin
          want_px = pixel_q.pop_front();
          px_bad = 1'b0;
          px_bad |= field_bad("red", want_px.red, out_data.red);
          px_bad |= field_bad("green", want_px.green, out_data.green);
          px_bad |= field_bad("blue", want_px.blue, out_data.blue);
          px_bad |= field_bad("alpha_out", want_px.alpha_out, out_data.alpha_out);
          px_bad |= field_bad("pixel_x", want_px.pixel_x, out_data.pixel_x);
          px_bad |= field_bad("pixel_y", want_px.pixel_y, out_data.pixel_y);
          px_bad |= field_bad("byte_offset", want_px.byte_offset, out_data.byte_offset);
          px_bad |= field_bad("last_pixel", want_px.last_pixel, out_data.last_pixel);
          if (px_bad) fail_count++;
        end
      end
      if (in_valid && !in_stall) decode_pixels(in_data);
    end
    pending = pixel_q.size();
  end

endmodule

>>> tb/sv/dxt_block_decode_tb.sv
// testbench top: block stimulus, stride writes, output backpressure and verdict
module dxt_block_decode_tb;
  import dxtd_pkg::*;

  localparam logic [1:0] FMT_UNUSED = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int PHASES = 5;
  localparam int BLOCKS_PER_PHASE = 22;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int          fail_count;
  int          pending;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  int unsigned cycle_cnt = 0;
  logic [15:0] phase_stride [PHASES];
  int          phase_send_idle [PHASES] = '{0, 59, 0, 9, 0};
  int          phase_recv_stall [PHASES] = '{0, 0, 59, 9, 0};

  dxt_block_decode u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  dxt_pixel_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d pixels outstanding", $time, pending);
      $display("dxt_block_decode_tb: FAIL");
      $finish;
    end
  end

  // receiver: a long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic in_item_t mk_block(input logic [63:0] colour, input logic [63:0] ahalf,
                                        input logic [1:0] fmt, input logic [2:0] cols,
                                        input logic [2:0] rows);
    in_item_t b;
    b.colour_half  = colour;
    b.alpha_half   = ahalf;
    b.block_format = fmt;
    b.cols_valid   = cols;
    b.rows_valid   = rows;
    return b;
  endfunction

  function automatic in_item_t rand_block();
    in_item_t b;
    b.colour_half  = {$urandom, $urandom};
    b.alpha_half   = {$urandom, $urandom};
    b.block_format = ($urandom_range(9) == 0) ? FMT_UNUSED : 2'($urandom_range(2));
    if ($urandom_range(3) == 0) begin
      b.cols_valid = 3'($urandom_range(7));
      b.rows_valid = 3'($urandom_range(7));
    end else if ($urandom_range(1) == 0) begin
      b.cols_valid = 3'd4;
      b.rows_valid = 3'd4;
    end else begin
      b.cols_valid = 3'($urandom_range(1, 4));
      b.rows_valid = 3'($urandom_range(1, 4));
    end
    return b;
  endfunction

  // entered and left at a falling edge
  task automatic send_block(input in_item_t blk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_stride(input logic [15:0] stride);
    cfg_valid <= 1'b1;
    cfg_data  <= stride;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // empty-clip blocks produce nothing, so keep waiting after the last expected pixel arrives
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    phase_stride[0] = 16'hffff;
    phase_stride[1] = 16'h0000;
    phase_stride[2] = 16'd4;
    phase_stride[3] = 16'($urandom_range(65535));
    phase_stride[4] = 16'd16;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed blocks at the reset stride
    send_block(mk_block({32'h1b1b_e4e4, 16'h0000, 16'hffff}, '0, FMT_DXT1, 3'd4, 3'd4));
    send_block(mk_block({32'he4e4_e4e4, 16'hffff, 16'h0000}, '1, FMT_DXT1, 3'd4, 3'd4));
    send_block(mk_block({32'hffff_ffff, 16'h8410, 16'h8410}, '0, FMT_DXT1, 3'd4, 3'd4));
    send_block(mk_block({32'he4e4_e4e4, 16'hf800, 16'h07e0}, '0, FMT_DXT1, 3'd4, 3'd2));
    send_block(mk_block({32'he4e4_e4e4, 16'hffff, 16'h0000}, 64'hfedc_ba98_7654_3210,
                        FMT_DXT3, 3'd4, 3'd4));
    send_block(mk_block('1, '1, FMT_DXT3, 3'd4, 3'd4));
    send_block(mk_block({32'h9c9c_3636, 16'h001f, 16'hf81f}, {48'o7654321076543210, 16'h00ff},
                        FMT_DXT5, 3'd4, 3'd4));
    send_block(mk_block({32'he4e4_e4e4, 16'h1234, 16'h5678}, {48'o7654321076543210, 16'hff00},
                        FMT_DXT5, 3'd4, 3'd4));
    send_block(mk_block({32'h0123_4567, 16'habcd, 16'h4321}, {48'o0123456701234567, 16'h8080},
                        FMT_DXT5, 3'd4, 3'd4));
    send_block(mk_block('1, '1, FMT_DXT5, 3'd4, 3'd4));
    send_block(mk_block('0, '0, FMT_DXT5, 3'd4, 3'd4));
    send_block(mk_block({32'he4e4_e4e4, 16'h0000, 16'hffff}, '0, FMT_UNUSED, 3'd4, 3'd4));
    send_block(mk_block('1, '0, FMT_UNUSED, 3'd2, 3'd3));
    send_block(mk_block({$urandom, $urandom}, '0, FMT_DXT1, 3'd1, 3'd1));
    send_block(mk_block({$urandom, $urandom}, {$urandom, $urandom}, FMT_DXT3, 3'd4, 3'd1));
    send_block(mk_block({$urandom, $urandom}, {$urandom, $urandom}, FMT_DXT5, 3'd1, 3'd4));
    send_block(mk_block({$urandom, $urandom}, {$urandom, $urandom}, FMT_DXT1, 3'd3, 3'd2));
    // empty clips
    send_block(mk_block({$urandom, $urandom}, '0, FMT_DXT1, 3'd0, 3'd3));
    send_block(mk_block({$urandom, $urandom}, '0, FMT_DXT3, 3'd2, 3'd0));
    send_block(mk_block({$urandom, $urandom}, '0, FMT_DXT5, 3'd0, 3'd0));
    // clip values past four clamp
    send_block(mk_block({$urandom, $urandom}, {$urandom, $urandom}, FMT_DXT1, 3'd7, 3'd7));
    send_block(mk_block({$urandom, $urandom}, {$urandom, $urandom}, FMT_DXT5, 3'd5, 3'd3));
    send_block(mk_block({$urandom, $urandom}, {$urandom, $urandom}, FMT_DXT3, 3'd6, 3'd1));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_stride(phase_stride[ph]);
      sender_idle_pct = phase_send_idle[ph];
      recv_stall_pct  = phase_recv_stall[ph];
      // back the block up while the sender keeps offering blocks
      if (ph == 0) hold_left = 300;
      repeat (BLOCKS_PER_PHASE) send_block(rand_block());
    end

    wait_drained();
    repeat (12) @(negedge clk);
    if (pending != 0)
      $display("%0t: %0d expected pixels never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("dxt_block_decode_tb: PASS");
    end else begin
      $display("dxt_block_decode_tb: FAIL");
    end
    $finish;
  end

endmodule
